FILE: src/positional_array_list_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional array list
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/pal_pkg.sv
// ---------------------------------------------------------------------------
// pal_pkg
// Types, codes and sizes shared by the positional array list files.
// ---------------------------------------------------------------------------
package pal_pkg;

   localparam int DEPTH_DEF       = 64;
   localparam int ENTRY_WIDTH_DEF = 32;
   localparam int DEPTH_MAX       = 1024;

   // Port field widths
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int LEN_W    = 7;

   // Cell index compare width, wide enough for any supported depth
   localparam int CELL_IDX_W = $clog2(DEPTH_MAX);

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FRONT = 3'd0,
      FN_INS_END   = 3'd1,
      FN_INS_AT    = 3'd2,
      FN_REM_FRONT = 3'd3,
      FN_REM_END   = 3'd4,
      FN_REM_AT    = 3'd5,
      FN_DUMP      = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_DUMP = 1'b1
   } fsm_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type             op;
      logic [CELL_IDX_W-1:0]   pos;   // insert / remove index
      logic [CELL_IDX_W-1:0]   tail;  // index of the last valid entry
   } cell_ctl_type;

endpackage

FILE: src/pal_if.sv
// ---------------------------------------------------------------------------
// pal_req_if / pal_rsp_if
// Valid/ready channels for list requests and list results.
// ---------------------------------------------------------------------------
interface pal_req_if;
   import pal_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [POS_W-1:0]     position;
   logic [VALUE_W-1:0]   entry_value;

   modport source (output valid, func, position, entry_value, input ready);
   modport sink   (input valid, func, position, entry_value, output ready);
endinterface

interface pal_rsp_if;
   import pal_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [VALUE_W-1:0]   entry_out;
   logic [INDEX_W-1:0]   entry_index;
   logic [LEN_W-1:0]     list_length;
   logic                 last;

   modport source (output valid, status, entry_out, entry_index, list_length, last,
                   input ready);
   modport sink   (input valid, status, entry_out, entry_index, list_length, last,
                   output ready);
endinterface

FILE: src/positional_array_list.sv
// ---------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to DEPTH entries kept in a row of shifting cells.
// ---------------------------------------------------------------------------
//
//   channel   direction  contents
//   --------  ---------  ----------------------------------------------
//   req_if    in         func, position, entry_value
//   rsp_if    out        status, entry_out, entry_index, list_length, last
//
// Any insert or remove finishes in the cycle it is accepted: every cell
// picks its left neighbor, right neighbor, the new entry or itself in one
// step. An accepted dump enters the dump state, which then streams one
// entry per cycle while the result slot is free, rotating the row so cell
// 0 always shows the next entry; no request is taken until the final entry
// is loaded. A stalled result holds in the output register. Reset clears
// count and control only; slot contents are never cleared.
// ---------------------------------------------------------------------------
module positional_array_list #(
   parameter int DEPTH       = pal_pkg::DEPTH_DEF,
   parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pal_req_if.sink      req_if,
   pal_rsp_if.source    rsp_if
);
   import pal_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // list and sequencing state
   logic [CNT_W-1:0]     count_ff, count_in;
   fsm_type              state_ff, state_in;
   logic [IDX_W-1:0]     dump_idx_ff, dump_idx_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_entry_ff, rsp_entry_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic                 rsp_last_ff, rsp_last_in;

   // cell row
   cell_ctl_type               cell_ctl;
   logic [ENTRY_WIDTH-1:0]     slot_value [DEPTH];
   logic [ENTRY_WIDTH-1:0]     slot_match [DEPTH];
   logic [ENTRY_WIDTH-1:0]     removed;
   logic [ENTRY_WIDTH-1:0]     new_value;

   // decode of the request at the port
   logic                 accept;
   logic                 slot_free;
   logic                 dump_emit;
   logic                 dump_last;
   logic                 full;
   logic                 empty;
   logic [CMP_W-1:0]     count_ext;
   logic [CMP_W-1:0]     at;
   cell_op_type          dec_op;
   status_type           dec_status;
   logic                 dec_remove;
   logic                 dec_dump;
   logic [CNT_W-1:0]     dec_count;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign accept    = req_if.valid && req_if.ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign count_ext = CMP_W'(count_ff);
   assign new_value = ENTRY_WIDTH'(req_if.entry_value);
   assign dump_last = (dump_idx_ff == IDX_W'(count_ff - CNT_W'(1)));

   // Work out the operation, its target index and its status.
   always_comb begin
      dec_op     = CELL_HOLD;
      dec_status = ST_OK;
      dec_remove = 1'b0;
      dec_dump   = 1'b0;
      dec_count  = count_ff;
      at         = '0;
      case (req_if.func)
         FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
            if (req_if.func == FN_INS_END) begin
               at = count_ext;
            end else if (req_if.func == FN_INS_AT) begin
               at = CMP_W'(req_if.position);
            end
            if (full) begin
               dec_status = ST_FULL;
            end else if (at > count_ext) begin
               dec_status = ST_RANGE;
            end else begin
               dec_op    = CELL_INSERT;
               dec_count = count_ff + CNT_W'(1);
            end
         end
         FN_REM_FRONT, FN_REM_END, FN_REM_AT: begin
            if (req_if.func == FN_REM_END) begin
               at = count_ext - CMP_W'(1);
            end else if (req_if.func == FN_REM_AT) begin
               at = CMP_W'(req_if.position);
            end
            if (empty) begin
               dec_status = ST_EMPTY;
            end else if (at >= count_ext) begin
               dec_status = ST_RANGE;
            end else begin
               dec_op     = CELL_REMOVE;
               dec_remove = 1'b1;
               dec_count  = count_ff - CNT_W'(1);
            end
         end
         FN_DUMP: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_dump = 1'b1;
            end
         end
         default: begin
            dec_op = CELL_HOLD;
         end
      endcase
   end

   // FSM: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && dec_dump) begin
               state_in = FSM_DUMP;
            end
         end
         FSM_DUMP: begin
            if (dump_emit && dump_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // FSM: outputs
   always_comb begin
      req_if.ready = 1'b0;
      dump_emit    = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_if.ready = slot_free;
         end
         FSM_DUMP: begin
            dump_emit = slot_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   // Broadcast to the cells: apply an accepted request, rotate on a dump step.
   always_comb begin
      cell_ctl.op   = CELL_HOLD;
      cell_ctl.pos  = CELL_IDX_W'(at);
      cell_ctl.tail = CELL_IDX_W'(count_ff - CNT_W'(1));
      if (accept) begin
         cell_ctl.op = dec_op;
      end else if (dump_emit) begin
         cell_ctl.op = CELL_ROTATE;
      end
   end

   // Row of cells; ends see zero from outside.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] left_value;
      logic [ENTRY_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_l
         assign left_value = slot_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_r
         assign right_value = slot_value[i+1];
      end

      pal_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .new_value   (new_value),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (slot_value[0]),
         .value       (slot_value[i]),
         .match_value (slot_match[i])
      );
   end

   // Gather the entry at the remove index; only that cell drives nonzero.
   always_comb begin
      removed = '0;
      for (int i = 0; i < DEPTH; i++) begin
         removed = removed | slot_match[i];
      end
   end

   // Next count and dump index
   always_comb begin
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      if (accept) begin
         count_in    = dec_count;
         dump_idx_in = '0;
      end else if (dump_emit) begin
         dump_idx_in = dump_idx_ff + IDX_W'(1);
      end
   end

   // Result register: load a request result, a dump entry, or drop when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      if (accept) begin
         rsp_valid_in  = !dec_dump;
         rsp_status_in = dec_status;
         rsp_entry_in  = dec_remove ? VALUE_W'(removed) : '0;
         rsp_index_in  = '0;
         rsp_len_in    = LEN_W'(dec_count);
         rsp_last_in   = 1'b1;
      end else if (dump_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_entry_in  = VALUE_W'(slot_value[0]);
         rsp_index_in  = INDEX_W'(dump_idx_ff);
         rsp_len_in    = LEN_W'(count_ff);
         rsp_last_in   = dump_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         state_ff     <= FSM_IDLE;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         state_ff     <= state_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.entry_out   = rsp_entry_ff;
   assign rsp_if.entry_index = rsp_index_ff;
   assign rsp_if.list_length = rsp_len_ff;
   assign rsp_if.last        = rsp_last_ff;

endmodule

FILE: src/pal_cell.sv
// ---------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry and shifts with its neighbors.
// ---------------------------------------------------------------------------
module pal_cell #(
   parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF,
   parameter int INDEX       = 0
) (
   input  logic                     clock,
   input  pal_pkg::cell_ctl_type    ctl,
   input  logic [ENTRY_WIDTH-1:0]   new_value,
   input  logic [ENTRY_WIDTH-1:0]   left_value,
   input  logic [ENTRY_WIDTH-1:0]   right_value,
   input  logic [ENTRY_WIDTH-1:0]   head_value,
   output logic [ENTRY_WIDTH-1:0]   value,
   output logic [ENTRY_WIDTH-1:0]   match_value
);
   import pal_pkg::*;

   localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

   logic [ENTRY_WIDTH-1:0] slot_ff;
   logic [ENTRY_WIDTH-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (MY_IDX > ctl.pos) begin
               slot_in = left_value;
            end else if (MY_IDX == ctl.pos) begin
               slot_in = new_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= ctl.pos) begin
               slot_in = right_value;
            end
         end
         CELL_ROTATE: begin
            // last valid slot wraps the head around
            if (MY_IDX == ctl.tail) begin
               slot_in = head_value;
            end else if (MY_IDX < ctl.tail) begin
               slot_in = right_value;
            end
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign value       = slot_ff;
   assign match_value = (MY_IDX == ctl.pos) ? slot_ff : '0;

endmodule

FILE: src/pal_checker.sv
// ---------------------------------------------------------------------------
// pal_checker
// Port-level checks for the positional array list, bound to the top level.
// ---------------------------------------------------------------------------
`include "positional_array_list_assert.svh"

module pal_checker #(
   parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pal_pkg::STATUS_W-1:0]   rsp_status,
   input logic [pal_pkg::VALUE_W-1:0]    rsp_entry_out,
   input logic [pal_pkg::INDEX_W-1:0]    rsp_entry_index,
   input logic [pal_pkg::LEN_W-1:0]      rsp_list_length,
   input logic                           rsp_last
);
   import pal_pkg::*;

   localparam int BUNDLE_W = STATUS_W + VALUE_W + INDEX_W + LEN_W + 1;

   logic                stalled;
   logic                dump_mid;
   logic                full_err;
   logic                empty_err;
   logic                empty_clean;
   logic [BUNDLE_W-1:0] rsp_bundle;

   assign stalled     = rsp_valid && !rsp_ready;
   assign dump_mid    = rsp_valid && !rsp_last;
   assign full_err    = rsp_valid && (rsp_status == ST_FULL);
   assign empty_err   = rsp_valid && (rsp_status == ST_EMPTY);
   assign empty_clean = (rsp_list_length == '0) && (rsp_entry_out == '0);
   assign rsp_bundle  = {rsp_status, rsp_entry_out, rsp_entry_index, rsp_list_length, rsp_last};

   // a stalled result holds
   `PAL_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_bundle), "stalled result changed")

   // no new request while a dump is still streaming
   `PAL_ASSERT_NOW(a_dump_blocks, dump_mid, !(req_valid && req_ready), "request taken during dump")

   // dump entries before the final one are always good
   `PAL_ASSERT_NOW(a_dump_ok, dump_mid, rsp_status == ST_OK, "dump entry with error")

   // a full error reports a full list
   `PAL_ASSERT_NOW(a_full_len, full_err, rsp_list_length == LEN_W'(DEPTH), "full error, list not full")

   // an empty error reports an empty list and no entry
   `PAL_ASSERT_NOW(a_empty_len, empty_err, empty_clean, "empty error with entries")

endmodule

bind positional_array_list pal_checker #(
   .DEPTH (DEPTH)
) u_pal_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_entry_out   (rsp_if.entry_out),
   .rsp_entry_index (rsp_if.entry_index),
   .rsp_list_length (rsp_if.list_length),
   .rsp_last        (rsp_if.last)
);

FILE: tb/list_result_checker.sv
// ---------------------------------------------------------------------------
// list_result_checker
// Watches the request and result channels of the positional array list,
// keeps a shadow copy of the list, and compares every result field by
// field with the oldest one still due.
// ---------------------------------------------------------------------------
module list_result_checker (
   input  logic  clock,
   input  logic  reset,
   pal_req_if    req_if,
   pal_rsp_if    rsp_if,
   output int    fail_count,
   output int    results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  entry_out;
      logic [INDEX_W-1:0]  entry_index;
      logic [LEN_W-1:0]    list_length;
      logic                last;
   } list_result_type;

   logic [VALUE_W-1:0] list_shadow[$];
   list_result_type    due_results[$];

   // Apply one request to the shadow list and queue the results it causes.
   task automatic apply_list_request(input func_type op, input logic [POS_W-1:0] pos,
                                     input logic [VALUE_W-1:0] value);
      int                 size;
      int                 at;
      status_type         status;
      logic [VALUE_W-1:0] removed;
      size    = list_shadow.size();
      status  = ST_OK;
      removed = '0;
      case (op)
         FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
            at = (op == FN_INS_FRONT) ? 0 : (op == FN_INS_END) ? size : int'(pos);
            if (size >= LIST_DEPTH) begin
               status = ST_FULL;
            end else if (at > size) begin
               status = ST_RANGE;
            end else begin
               list_shadow.insert(at, value);
            end
         end
         FN_REM_FRONT, FN_REM_END, FN_REM_AT: begin
            at = (op == FN_REM_FRONT) ? 0 : (op == FN_REM_END) ? size - 1 : int'(pos);
            if (size == 0) begin
               status = ST_EMPTY;
            end else if (at >= size) begin
               status = ST_RANGE;
            end else begin
               removed = list_shadow[at];
               list_shadow.delete(at);
            end
         end
         FN_DUMP: begin
            if (size == 0) begin
               due_results.push_back('{ST_EMPTY, '0, '0, '0, 1'b1});
            end else begin
               for (int i = 0; i < size; i++) begin
                  due_results.push_back('{ST_OK, list_shadow[i], INDEX_W'(i), LEN_W'(size),
                                          (i == size - 1)});
               end
            end
            return;
         end
         default: ;
      endcase
      due_results.push_back('{status, removed, '0, LEN_W'(list_shadow.size()), 1'b1});
   endtask

   task automatic compare_result();
      list_result_type want;
      if (due_results.size() == 0) begin
         $error("result with no request outstanding: entry_out %h", rsp_if.entry_out);
         fail_count++;
         return;
      end
      want = due_results.pop_front();
      if (rsp_if.status !== want.status) begin
         $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
         fail_count++;
      end
      if (rsp_if.entry_out !== want.entry_out) begin
         $error("entry_out mismatch: expected %h, got %h", want.entry_out, rsp_if.entry_out);
         fail_count++;
      end
      if (rsp_if.entry_index !== want.entry_index) begin
         $error("entry_index mismatch: expected %0d, got %0d", want.entry_index,
                rsp_if.entry_index);
         fail_count++;
      end
      if (rsp_if.list_length !== want.list_length) begin
         $error("list_length mismatch: expected %0d, got %0d", want.list_length,
                rsp_if.list_length);
         fail_count++;
      end
      if (rsp_if.last !== want.last) begin
         $error("last mismatch: expected %0d, got %0d", want.last, rsp_if.last);
         fail_count++;
      end
   endtask

   // Results leave the block through its result register after their request,
   // so check the result side of an edge before predicting the request side.
   always @(posedge clock) begin
      if (reset) begin
         list_shadow.delete();
         due_results.delete();
      end else begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            compare_result();
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            apply_list_request(func_type'(req_if.func), req_if.position, req_if.entry_value);
         end
      end
      results_due <= due_results.size();
   end

endmodule

FILE: tb/tb_positional_array_list.sv
// ---------------------------------------------------------------------------
// tb_positional_array_list
// Drives list requests into the positional array list and gives the verdict.
// A directed opening covers empty, range and boundary cases; a random part
// then mixes operations, fills the list to full and drains it again, while
// both channels idle at random and the result side stalls once for long.
// ---------------------------------------------------------------------------
module tb_positional_array_list;
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEF;
   localparam int HOLD_AFTER   = 35;        // requests accepted before the long stall
   localparam int HOLD_CYCLES  = 300;       // length of the long result stall
   localparam int DRAIN_CYCLES = 10;        // quiet cycles after the last result
   localparam int RUN_LIMIT_NS = 8_000_000; // watchdog

   logic clock;
   logic reset;
   int   fail_count;
   int   results_due;
   int   req_count;
   int   list_len;     // length of the list as the stimulus sees it, for shaping only
   bit   burst_mode;   // drop sender gaps while set

   pal_req_if req_if ();
   pal_rsp_if rsp_if ();

   positional_array_list DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   list_result_checker u_result_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run if the list never settles.
   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   // Count accepted requests; the result side uses this to time its long stall.
   always @(posedge clock) begin
      if (reset) begin
         req_count <= 0;
      end else if (req_if.valid && req_if.ready) begin
         req_count <= req_count + 1;
      end
   end

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Entry handles: random, with the all-zero and all-one handles mixed in.
   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom();
   endfunction

   // Position for an insert: mostly legal, sometimes past the end.
   function automatic int pick_ins_pos();
      if (list_len < LIST_DEPTH && $urandom_range(0, 9) == 0) begin
         return $urandom_range(list_len + 1, LIST_DEPTH);
      end
      return $urandom_range(0, list_len);
   endfunction

   // Position for a remove: mostly an existing entry, sometimes out of range.
   function automatic int pick_rem_pos();
      if (list_len == 0 || $urandom_range(0, 9) == 0) begin
         return $urandom_range(list_len, LIST_DEPTH);
      end
      return $urandom_range(0, list_len - 1);
   endfunction

   // Offer one request and hold it until the block takes it. Valid stays
   // high across back-to-back requests so it is never lowered and raised
   // in the same step.
   task automatic send_request(input func_type op, input int pos,
                               input logic [VALUE_W-1:0] value);
      int gap;
      int at;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.func        <= op;
      req_if.position    <= pos[POS_W-1:0];
      req_if.entry_value <= value;
      do @(posedge clock); while (!req_if.ready);
      // advance the shaping length the way the block would
      case (op)
         FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
            at = (op == FN_INS_FRONT) ? 0 : (op == FN_INS_END) ? list_len : pos;
            if (list_len < LIST_DEPTH && at <= list_len) list_len++;
         end
         FN_REM_FRONT, FN_REM_END, FN_REM_AT: begin
            at = (op == FN_REM_AT) ? pos : 0;
            if (list_len > 0 && at < list_len) list_len--;
         end
         default: ;
      endcase
   endtask

   // One random request; insert_share is the percent chance of an insert.
   task automatic send_random(input int insert_share);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_share) begin
         case ($urandom_range(0, 2))
            0:       send_request(FN_INS_FRONT, $urandom_range(0, LIST_DEPTH), pick_value());
            1:       send_request(FN_INS_END, $urandom_range(0, LIST_DEPTH), pick_value());
            default: send_request(FN_INS_AT, pick_ins_pos(), pick_value());
         endcase
      end else if (roll < 92) begin
         case ($urandom_range(0, 2))
            0:       send_request(FN_REM_FRONT, $urandom_range(0, LIST_DEPTH), pick_value());
            1:       send_request(FN_REM_END, $urandom_range(0, LIST_DEPTH), pick_value());
            default: send_request(FN_REM_AT, pick_rem_pos(), pick_value());
         endcase
      end else begin
         send_request(FN_DUMP, $urandom_range(0, LIST_DEPTH), pick_value());
      end
   endtask

   // Result side: random ready stretches, plus one long hold-off once the
   // sender is well into the random part, so the block backs up and stalls
   // its request side.
   initial begin : result_drain
      int  stretch;
      int  roll;
      bit  hold_done;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && req_count >= HOLD_AFTER) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            roll = $urandom_range(0, 9);
            rsp_if.ready <= (roll < 7);
            if (roll < 6)       stretch = $urandom_range(1, 8);
            else if (roll == 6) stretch = $urandom_range(40, 100);  // no idling at all
            else if (roll < 9)  stretch = $urandom_range(1, 3);
            else                stretch = $urandom_range(10, 40);
            repeat (stretch) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.func        <= FN_INS_FRONT;
      req_if.position    <= '0;
      req_if.entry_value <= '0;
      burst_mode = 1'b0;
      list_len   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: removes, a dump and inserts on an empty list, then range errors,
      // the handle extremes and removes from the front, middle and end.
      send_request(FN_REM_FRONT, 0, '0);
      send_request(FN_REM_END, 0, '0);
      send_request(FN_REM_AT, 0, '0);
      send_request(FN_DUMP, 0, '0);
      send_request(FN_INS_AT, 1, 32'h1111_1111);        // past the end of an empty list
      send_request(FN_INS_AT, LIST_DEPTH, 32'h2222_2222);
      send_request(FN_INS_FRONT, 0, 32'hFFFF_FFFF);
      send_request(FN_INS_END, 0, 32'h0000_0000);
      send_request(FN_INS_AT, 1, 32'hA5A5_A5A5);
      send_request(FN_INS_AT, 3, 32'h5A5A_5A5A);        // position equal to length appends
      send_request(FN_INS_AT, 0, 32'h1234_5678);
      send_request(FN_DUMP, 0, '0);
      send_request(FN_REM_AT, 5, '0);                   // position equal to length
      send_request(FN_REM_AT, LIST_DEPTH, '0);
      send_request(FN_REM_AT, 2, '0);
      send_request(FN_REM_FRONT, 0, '0);
      send_request(FN_REM_END, 0, '0);
      send_request(FN_DUMP, 0, '0);
      send_request(FN_REM_AT, 1, '0);
      send_request(FN_REM_AT, 0, '0);
      send_request(FN_DUMP, 0, '0);

      // Random mix leaning toward inserts so the list grows.
      repeat (20) send_random(60);

      // Fill to full with no sender gaps, then hit the full list.
      burst_mode = 1'b1;
      while (list_len < LIST_DEPTH) send_random(100);
      burst_mode = 1'b0;
      send_request(FN_INS_FRONT, 0, pick_value());
      send_request(FN_INS_END, 0, pick_value());
      send_request(FN_INS_AT, LIST_DEPTH, pick_value());  // full wins over range
      send_request(FN_DUMP, 0, '0);
      send_request(FN_REM_AT, LIST_DEPTH, '0);
      send_request(FN_REM_AT, LIST_DEPTH - 1, '0);

      // Drain to empty, mostly removes, then remove from the empty list.
      while (list_len > 0) send_random(10);
      send_request(FN_REM_AT, LIST_DEPTH, '0);           // empty wins over range
      send_request(FN_DUMP, 0, '0);

      // Random mix again; the second half runs back to back.
      repeat (10) send_random(55);
      burst_mode = 1'b1;
      repeat (10) send_random(55);
      req_if.valid <= 1'b0;

      // Let the checker see the final request, then wait out every result.
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
